// File: hw/rtl/cmc_pkg.sv
// shared constants, types and command codes for the complex magnitude clipper
`timescale 1ns / 1ps
`default_nettype none

package cmc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 16;
    localparam int LIMIT_BITS  = SAMPLE_BITS - 1;
    localparam int SQ_BITS     = 2 * SAMPLE_BITS;
    localparam int NUM_BITS    = SAMPLE_BITS + LIMIT_BITS;
    localparam int ITER_BITS   = $clog2(SAMPLE_BITS + 1);

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = '1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ_I,
        OP_SQ_Q,
        OP_SQ_L,
        OP_CMP,
        OP_ROOT_INIT,
        OP_ROOT_STEP,
        OP_MUL_I,
        OP_MUL_Q,
        OP_DIV_STEP,
        OP_OUT
    } t_op;

    typedef struct packed {
        logic over;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: hw/rtl/complex_magnitude_clipper_top.sv
// top level of the complex magnitude clipper
//
// channel   direction  handshake          payload
// input     in         i_valid / o_stall  i_sample_i, i_sample_q, i_end_of_vector
// result    out        o_valid / i_stall  o_out_i, o_out_q, o_was_clipped,
//                                         o_clipped_total, o_end_flag
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_data (magnitude limit)
//
// one item at a time; a clipped item runs 16 square root steps and 15 divide steps
// (these steps dominate, both divider lanes run together)
// the output register frees the input side as soon as a result is written
// a stalled result holds the sequencer in its last state until taken
// synchronous active low reset; limit resets to all ones, clip count to zero
`timescale 1ns / 1ps
`default_nettype none

module complex_magnitude_clipper_top
    import cmc_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_i,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_q,
    input  wire logic                          i_end_of_vector,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed      [SAMPLE_BITS-1:0] o_out_i,
    output logic signed      [SAMPLE_BITS-1:0] o_out_q,
    output logic                               o_was_clipped,
    output logic             [COUNT_BITS-1:0]  o_clipped_total,
    output logic                               o_end_flag,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic        [LIMIT_BITS-1:0]  i_cfg_data
);

    t_op   op;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    cmc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_op    (op)
    );

    cmc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_sample_i      (i_sample_i),
        .i_sample_q      (i_sample_q),
        .i_end_of_vector (i_end_of_vector),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_i         (o_out_i),
        .o_out_q         (o_out_q),
        .o_was_clipped   (o_was_clipped),
        .o_clipped_total (o_clipped_total),
        .o_end_flag      (o_end_flag)
    );

endmodule

`default_nettype wire

// File: hw/rtl/cmc_ctrl.sv
// sequencer for the magnitude clipper datapath
`timescale 1ns / 1ps
`default_nettype none

module cmc_ctrl
    import cmc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_stall,
    input  wire t_stat i_stat,
    output t_op        o_op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_I,
        S_SQ_Q,
        S_SQ_L,
        S_CMP,
        S_DECIDE,
        S_ROOT,
        S_MUL_I,
        S_MUL_Q,
        S_DIV,
        S_OUT
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [ITER_BITS-1:0] r_iter;
    logic [ITER_BITS-1:0] n_iter;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_op    = OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_op    = OP_LOAD;
                    n_state = S_SQ_I;
                end
            end
            S_SQ_I: begin
                o_op    = OP_SQ_I;
                n_state = S_SQ_Q;
            end
            S_SQ_Q: begin
                o_op    = OP_SQ_Q;
                n_state = S_SQ_L;
            end
            S_SQ_L: begin
                o_op    = OP_SQ_L;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_op    = OP_CMP;
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                o_op    = OP_ROOT_INIT;
                n_iter  = '0;
                n_state = i_stat.over ? S_ROOT : S_OUT;
            end
            S_ROOT: begin
                o_op = OP_ROOT_STEP;
                if (r_iter == ITER_BITS'(SAMPLE_BITS - 1)) begin
                    n_state = S_MUL_I;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_MUL_I: begin
                o_op    = OP_MUL_I;
                n_state = S_MUL_Q;
            end
            S_MUL_Q: begin
                o_op    = OP_MUL_Q;
                n_iter  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_op = OP_DIV_STEP;
                if (r_iter == ITER_BITS'(LIMIT_BITS - 1)) begin
                    n_state = S_OUT;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cmc_dp.sv
// datapath: squares, compare, integer square root, two divider lanes, output register
`timescale 1ns / 1ps
`default_nettype none

module cmc_dp
    import cmc_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_op                           i_op,
    output t_stat                              o_stat,
    input  wire logic                          i_cfg_valid,
    input  wire logic        [LIMIT_BITS-1:0]  i_cfg_data,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_i,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_q,
    input  wire logic                          i_end_of_vector,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed      [SAMPLE_BITS-1:0] o_out_i,
    output logic signed      [SAMPLE_BITS-1:0] o_out_q,
    output logic                               o_was_clipped,
    output logic             [COUNT_BITS-1:0]  o_clipped_total,
    output logic                               o_end_flag
);

    logic [LIMIT_BITS-1:0]  r_limit;
    logic [SAMPLE_BITS-1:0] r_si;
    logic [SAMPLE_BITS-1:0] r_sq;
    logic [SAMPLE_BITS-1:0] r_ai;
    logic [SAMPLE_BITS-1:0] r_aq;
    logic                   r_last;
    logic [SQ_BITS-1:0]     r_s;
    logic [SQ_BITS-1:0]     r_ll;
    logic                   r_over;
    logic [SQ_BITS-1:0]     r_rad;
    logic [SAMPLE_BITS:0]   r_rem;
    logic [SAMPLE_BITS-1:0] r_root;
    logic [SAMPLE_BITS-1:0] r_drem_i;
    logic [SAMPLE_BITS-1:0] r_drem_q;
    logic [LIMIT_BITS-1:0]  r_dq_i;
    logic [LIMIT_BITS-1:0]  r_dq_q;
    logic [COUNT_BITS-1:0]  r_cnt;
    logic                   r_o_valid;

    logic [SAMPLE_BITS-1:0] mul_a;
    logic [SAMPLE_BITS-1:0] mul_b;
    logic [SQ_BITS-1:0]     prod;
    logic [SAMPLE_BITS-1:0] abs_i;
    logic [SAMPLE_BITS-1:0] abs_q;
    logic [SAMPLE_BITS+2:0] root_rem_t;
    logic [SAMPLE_BITS+2:0] root_trial;
    logic                   root_ge;
    logic [SAMPLE_BITS:0]   div_rem_i;
    logic [SAMPLE_BITS:0]   div_rem_q;
    logic [SAMPLE_BITS:0]   div_m;
    logic                   div_ge_i;
    logic                   div_ge_q;
    logic [SAMPLE_BITS-1:0] mag_i;
    logic [SAMPLE_BITS-1:0] mag_q;
    logic [COUNT_BITS-1:0]  cnt_inc;
    logic [COUNT_BITS-1:0]  cnt_show;

    assign abs_i = i_sample_i[SAMPLE_BITS-1] ? (~i_sample_i + 1'b1) : i_sample_i;
    assign abs_q = i_sample_q[SAMPLE_BITS-1] ? (~i_sample_q + 1'b1) : i_sample_q;

    always_comb begin
        mul_a = r_ai;
        mul_b = r_ai;
        case (i_op)
            OP_SQ_I: begin
                mul_a = r_ai;
                mul_b = r_ai;
            end
            OP_SQ_Q: begin
                mul_a = r_aq;
                mul_b = r_aq;
            end
            OP_SQ_L: begin
                mul_a = {1'b0, r_limit};
                mul_b = {1'b0, r_limit};
            end
            OP_MUL_I: begin
                mul_a = r_ai;
                mul_b = {1'b0, r_limit};
            end
            OP_MUL_Q: begin
                mul_a = r_aq;
                mul_b = {1'b0, r_limit};
            end
            default: begin
                mul_a = r_ai;
                mul_b = r_ai;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign root_rem_t = {r_rem, r_rad[SQ_BITS-1 -: 2]};
    assign root_trial = {1'b0, r_root, 2'b01};
    assign root_ge    = (root_rem_t >= root_trial);

    assign div_m     = {1'b0, r_root};
    assign div_rem_i = {r_drem_i, r_dq_i[LIMIT_BITS-1]};
    assign div_rem_q = {r_drem_q, r_dq_q[LIMIT_BITS-1]};
    assign div_ge_i  = (div_rem_i >= div_m);
    assign div_ge_q  = (div_rem_q >= div_m);

    assign mag_i = r_si[SAMPLE_BITS-1] ? (~{1'b0, r_dq_i} + 1'b1) : {1'b0, r_dq_i};
    assign mag_q = r_sq[SAMPLE_BITS-1] ? (~{1'b0, r_dq_q} + 1'b1) : {1'b0, r_dq_q};

    assign cnt_inc  = (r_cnt == '1) ? r_cnt : r_cnt + 1'b1;
    assign cnt_show = r_over ? cnt_inc : r_cnt;

    assign o_stat.over     = r_over;
    assign o_stat.out_free = !r_o_valid || !i_stall;
    assign o_valid         = r_o_valid;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (i_op == OP_OUT) begin
                r_o_valid <= 1'b1;
                r_cnt     <= r_last ? '0 : cnt_show;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_si   <= i_sample_i;
                r_sq   <= i_sample_q;
                r_ai   <= abs_i;
                r_aq   <= abs_q;
                r_last <= i_end_of_vector;
            end
            OP_SQ_I: begin
                r_s <= prod;
            end
            OP_SQ_Q: begin
                r_s <= r_s + prod;
            end
            OP_SQ_L: begin
                r_ll <= prod;
            end
            OP_CMP: begin
                r_over <= (r_s > r_ll);
            end
            OP_ROOT_INIT: begin
                r_rad  <= r_s;
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_ROOT_STEP: begin
                r_rad  <= {r_rad[SQ_BITS-3:0], 2'b00};
                r_rem  <= root_ge ? (SAMPLE_BITS+1)'(root_rem_t - root_trial)
                                  : root_rem_t[SAMPLE_BITS:0];
                r_root <= {r_root[SAMPLE_BITS-2:0], root_ge};
            end
            OP_MUL_I: begin
                r_drem_i <= prod[NUM_BITS-1:LIMIT_BITS];
                r_dq_i   <= prod[LIMIT_BITS-1:0];
            end
            OP_MUL_Q: begin
                r_drem_q <= prod[NUM_BITS-1:LIMIT_BITS];
                r_dq_q   <= prod[LIMIT_BITS-1:0];
            end
            OP_DIV_STEP: begin
                r_drem_i <= div_ge_i ? SAMPLE_BITS'(div_rem_i - div_m)
                                     : div_rem_i[SAMPLE_BITS-1:0];
                r_drem_q <= div_ge_q ? SAMPLE_BITS'(div_rem_q - div_m)
                                     : div_rem_q[SAMPLE_BITS-1:0];
                r_dq_i   <= {r_dq_i[LIMIT_BITS-2:0], div_ge_i};
                r_dq_q   <= {r_dq_q[LIMIT_BITS-2:0], div_ge_q};
            end
            OP_OUT: begin
                o_out_i         <= r_over ? mag_i : r_si;
                o_out_q         <= r_over ? mag_q : r_sq;
                o_was_clipped   <= r_over;
                o_clipped_total <= cnt_show;
                o_end_flag      <= r_last;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: tb/cmc_checker.sv
// checker for the complex magnitude clipper: predicts each clipped or passed sample and compares
`timescale 1ns / 1ps

module cmc_checker
    import cmc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_i,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_q,
    input  logic                          i_end_of_vector,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_out_i,
    input  logic signed [SAMPLE_BITS-1:0] i_out_q,
    input  logic                          i_was_clipped,
    input  logic        [COUNT_BITS-1:0]  i_clipped_total,
    input  logic                          i_end_flag,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic        [LIMIT_BITS-1:0]  i_cfg_data,
    output int                            o_pending,
    output int                            o_fail_count
);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_i;
        logic signed [SAMPLE_BITS-1:0] out_q;
        logic                          clipped;
        logic        [COUNT_BITS-1:0]  total;
        logic                          last;
    } t_clip_result;

    t_clip_result            expected_q[$];
    t_clip_result            got;
    t_clip_result            want;
    t_clip_result            predicted;
    logic [LIMIT_BITS-1:0]   limit_reg;
    logic [COUNT_BITS-1:0]   clip_count;
    int                      fail_count;

    task automatic predict_clip(
        input  logic signed [SAMPLE_BITS-1:0] si,
        input  logic signed [SAMPLE_BITS-1:0] sq,
        input  logic                          last,
        output t_clip_result                  r
    );
        longint          wide_i;
        longint          wide_q;
        longint unsigned abs_i;
        longint unsigned abs_q;
        longint unsigned power;
        longint unsigned lim;
        longint unsigned rem;
        longint unsigned root;
        longint unsigned bitv;
        wide_i    = 64'(si);
        wide_q    = 64'(sq);
        abs_i     = (wide_i < 0) ? -wide_i : wide_i;
        abs_q     = (wide_q < 0) ? -wide_q : wide_q;
        power     = abs_i * abs_i + abs_q * abs_q;
        lim       = 64'(limit_reg);
        r.out_i   = si;
        r.out_q   = sq;
        r.clipped = 1'b0;
        r.last    = last;
        if (power > lim * lim) begin
            // integer square root, two bits of the radicand per step
            rem  = power;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem)
                bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem  = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            abs_i     = (abs_i * lim) / root;
            abs_q     = (abs_q * lim) / root;
            r.out_i   = SAMPLE_BITS'((wide_i < 0) ? -abs_i : abs_i);
            r.out_q   = SAMPLE_BITS'((wide_q < 0) ? -abs_q : abs_q);
            r.clipped = 1'b1;
            if (clip_count != '1)
                clip_count = clip_count + 1'b1;
        end
        r.total = clip_count;
        if (last)
            clip_count = '0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_q.delete();
            limit_reg  = LIMIT_RESET;
            clip_count = '0;
            fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_out_i, i_out_q, i_was_clipped, i_clipped_total, i_end_flag};
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"%t: result with none expected: ",
                                  "i=%0d q=%0d clip=%0d total=%0d end=%0d"},
                                 $realtime, got.out_i, got.out_q, got.clipped, got.total,
                                 got.last);
                end else begin
                    want = expected_q.pop_front();
                    if (got.out_i !== want.out_i || got.out_q !== want.out_q ||
                        got.clipped !== want.clipped || got.total !== want.total ||
                        got.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%t: mismatch exp i=%0d q=%0d clip=%0d total=%0d ",
                                      "end=%0d, got i=%0d q=%0d clip=%0d total=%0d end=%0d"},
                                     $realtime, want.out_i, want.out_q, want.clipped,
                                     want.total, want.last, got.out_i, got.out_q,
                                     got.clipped, got.total, got.last);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                limit_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall) begin
                predict_clip(i_sample_i, i_sample_q, i_end_of_vector, predicted);
                expected_q.push_back(predicted);
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: tb/complex_magnitude_clipper_top_tb.sv
// testbench top for the complex magnitude clipper: stimulus, limit settings and verdict
`timescale 1ns / 1ps

module complex_magnitude_clipper_top_tb;
    import cmc_pkg::*;

    localparam int LIMIT_MAX      = (1 << LIMIT_BITS) - 1;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    logic signed [SAMPLE_BITS-1:0] i_sample_i;
    logic signed [SAMPLE_BITS-1:0] i_sample_q;
    logic                          i_end_of_vector;
    logic                          o_valid;
    logic                          i_stall;
    logic signed [SAMPLE_BITS-1:0] o_out_i;
    logic signed [SAMPLE_BITS-1:0] o_out_q;
    logic                          o_was_clipped;
    logic        [COUNT_BITS-1:0]  o_clipped_total;
    logic                          o_end_flag;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic        [LIMIT_BITS-1:0]  i_cfg_data;

    int pending_count;
    int fail_total;
    int send_gap_pct;
    int stall_pct;
    int quiet_cycles;

    int corner_parts[6] = '{-32768, -32767, -1, 0, 1, 32767};
    int directed_i[12]  = '{32767, -32768, -32768, 32767, 0, 1, -1, 23170, -23171, 0,
                            32767, -32768};
    int directed_q[12]  = '{32767, -32768, 0, 0, 0, -1, 0, 23170, 23170, -32768,
                            -32768, 32767};
    int block_items[4]  = '{250, 250, 100, 100};

    always #1 i_clk = ~i_clk;

    complex_magnitude_clipper_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample_i      (i_sample_i),
        .i_sample_q      (i_sample_q),
        .i_end_of_vector (i_end_of_vector),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_out_i         (o_out_i),
        .o_out_q         (o_out_q),
        .o_was_clipped   (o_was_clipped),
        .o_clipped_total (o_clipped_total),
        .o_end_flag      (o_end_flag),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    cmc_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_valid),
        .i_in_stall      (o_stall),
        .i_sample_i      (i_sample_i),
        .i_sample_q      (i_sample_q),
        .i_end_of_vector (i_end_of_vector),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_out_i         (o_out_i),
        .i_out_q         (o_out_q),
        .i_was_clipped   (o_was_clipped),
        .i_clipped_total (o_clipped_total),
        .i_end_flag      (o_end_flag),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_pending       (pending_count),
        .o_fail_count    (fail_total)
    );

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL complex_magnitude_clipper_top");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(input int si, input int sq, input logic last);
        if ($urandom_range(0, 39) == 0) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while (pending_count != 0)
                @(posedge i_clk);
        end
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_valid         <= 1'b0;
            i_sample_i      <= SAMPLE_BITS'($urandom);
            i_sample_q      <= SAMPLE_BITS'($urandom);
            i_end_of_vector <= 1'($urandom_range(0, 1));
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sample_i      <= SAMPLE_BITS'(si);
        i_sample_q      <= SAMPLE_BITS'(sq);
        i_end_of_vector <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input int lim);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= LIMIT_BITS'(lim);
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // half of the samples on or near the limit circle, the rest full-range or corner parts
    task automatic random_sample(input int lim);
        int pick;
        int a;
        int b;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            a = $signed($urandom_range(0, 65535)) - 32768;
            b = $signed($urandom_range(0, 65535)) - 32768;
        end else if (pick < 8) begin
            a = $urandom_range(0, lim);
            b = $rtoi($sqrt(real'(lim) * lim - real'(a) * a)) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1))
                a = -a;
            if ($urandom_range(0, 1))
                b = -b;
        end else begin
            a = corner_parts[$urandom_range(0, 5)];
            b = corner_parts[$urandom_range(0, 5)];
        end
        send_sample(a, b, ($urandom_range(0, 9) == 0));
    endtask

    initial begin
        int lim;
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_sample_i      <= '0;
        i_sample_q      <= '0;
        i_end_of_vector <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        send_gap_pct = 31;
        stall_pct    = 55;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner samples at the reset limit, then with a zero limit
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 1)
                write_limit(0);
            for (int k = 0; k < 12; k++)
                send_sample(directed_i[k], directed_q[k], (k == 5 || k == 11));
        end

        for (int blk = 0; blk < 4; blk++) begin
            case (blk)
                0: begin
                    lim = $urandom_range(2, LIMIT_MAX - 1);
                end
                1: begin
                    lim          = $urandom_range(1, 255);
                    send_gap_pct = 55;
                    stall_pct    = 31;
                end
                2: begin
                    lim          = 1;
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                default: begin
                    lim = LIMIT_MAX;
                end
            endcase
            write_limit(lim);
            for (int n = 0; n < block_items[blk]; n++)
                random_sample(lim);
        end

        drain_results();
        if (fail_total == 0)
            $display("PASS complex_magnitude_clipper_top");
        else
            $display("FAIL complex_magnitude_clipper_top");
        $finish;
    end

endmodule

// File: complex_magnitude_clipper_top.f
hw/rtl/cmc_pkg.sv
hw/rtl/cmc_ctrl.sv
hw/rtl/cmc_dp.sv
hw/rtl/complex_magnitude_clipper_top.sv
tb/cmc_checker.sv
tb/complex_magnitude_clipper_top_tb.sv
